[design/cfrl_pkg.sv]
// Shared definitions for the CAN identifier filter with rate limit.
// Holds the mode codes, command lengths and the search token that runs the cell chain.
// No dependencies.
package cfrl_pkg;

  // Default table depth.
  localparam int unsigned MAX_ENTRIES_DEF = 64;

  // Item modes.
  localparam logic [1:0] MODE_FRAME     = 2'd0;
  localparam logic [1:0] MODE_DENY_ALL  = 2'd1;
  localparam logic [1:0] MODE_ALLOW_ALL = 2'd2;
  localparam logic [1:0] MODE_ALLOW_ONE = 2'd3;

  // Required command byte lengths.
  localparam logic [7:0] LEN_DENY_ALL  = 8'd1;
  localparam logic [7:0] LEN_ALLOW_ALL = 8'd3;
  localparam logic [7:0] LEN_ALLOW_ONE = 8'd7;

  // Token that walks the chain of table cells, one cell per cycle.
  typedef struct packed {
    logic        valid;     // token present
    logic        is_frame;  // 1: frame lookup, 0: allow-one command
    logic        ins_en;    // an unknown identifier may be added
    logic [31:0] ident;     // identifier searched for
    logic [31:0] now;       // frame time
    logic [15:0] interval;  // interval for a new or updated entry
    logic        found;     // an earlier cell held the identifier
    logic        inserted;  // a free cell took the identifier
    logic        notify;    // the frame is passed on
  } tok_t;

endpackage

[design/cfrl_cell.sv]
// One table entry of the identifier filter, as a cell of the search chain.
// Compares, updates or fills its entry as the token passes, then hands the token on.
// Depends on cfrl_pkg.
module cfrl_cell #(
  parameter int unsigned MAX_ENTRIES = cfrl_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned IDX         = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]     count_i,
  input  cfrl_pkg::tok_t                       tok_i,
  output cfrl_pkg::tok_t                       tok_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [31:0] ident_q, ident_d;
  logic [15:0] interval_q, interval_d;
  logic [31:0] last_q, last_d;
  logic        seen_q, seen_d;
  cfrl_pkg::tok_t tok_q, tok_d;

  logic in_use, at_free, hit, fill, hold;
  logic [31:0] elapsed;

  assign in_use  = IDX_C < count_i;
  assign at_free = IDX_C == count_i;
  assign elapsed = tok_i.now - last_q;
  assign hold    = seen_q && (interval_q != 16'd0) && (elapsed < {16'd0, interval_q});
  assign hit     = tok_i.valid && in_use && !tok_i.found && (ident_q == tok_i.ident);
  assign fill    = tok_i.valid && at_free && !tok_i.found && tok_i.ins_en;

  always_comb begin
    ident_d    = ident_q;
    interval_d = interval_q;
    last_d     = last_q;
    seen_d     = seen_q;
    tok_d      = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      if (tok_i.is_frame) begin
        if (!hold) begin
          seen_d       = 1'b1;
          last_d       = tok_i.now;
          tok_d.notify = 1'b1;
        end
      end else begin
        interval_d = tok_i.interval;
      end
    end else if (fill) begin
      // A new entry passes its first frame at once.
      tok_d.inserted = 1'b1;
      ident_d        = tok_i.ident;
      interval_d     = tok_i.interval;
      if (tok_i.is_frame) begin
        seen_d       = 1'b1;
        last_d       = tok_i.now;
        tok_d.notify = 1'b1;
      end else begin
        seen_d = 1'b0;
        last_d = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ident_q    <= ident_d;
    interval_q <= interval_d;
    last_q     <= last_d;
    seen_q     <= seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[design/can_id_filter_rate_limiter.sv]
// CAN identifier acceptance filter with a per-identifier rate limit.
// Top level: command handling, drop counter, result register and the cell chain.
// Depends on cfrl_pkg and cfrl_cell.
//
// Usage: each input transaction carries a mode, an identifier, a time stamp, an
// interval and a command length. A frame transaction looks up its identifier
// and reports whether the frame is passed on. Deny-all, allow-all and
// allow-one command transactions change the table and report whether they
// were applied. Every input transaction yields exactly one output transaction
// with the drop count and the number of table entries after it.
//
// Deny-all, allow-all and any command with a wrong length go straight to the
// result register. Frames and valid allow-one commands send a token down the
// chain of MAX_ENTRIES cells, one cell per cycle, from the launch register
// through each cell register, and the token leaving the last cell posts the
// result in the result register. No new transaction is taken until that
// token has left the last cell.
//
// Reset empties the table, selects deny mode and clears the drop count and
// the default interval. While the receiver stalls a waiting result, no new
// transaction is taken; results are never lost or repeated.
module can_id_filter_rate_limiter #(
  parameter int unsigned MAX_ENTRIES = cfrl_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic [31:0]                        can_id_i,
  input  logic [31:0]                        now_ms_i,
  input  logic [15:0]                        interval_ms_i,
  input  logic [7:0]                         cmd_length_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               notify_o,
  output logic                               accepted_o,
  output logic [31:0]                        dropped_count_o,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]   entries_used_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  // Controller states.
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      drop_q, drop_d;
  logic             allow_all_q, allow_all_d;
  logic [15:0]      dflt_q, dflt_d;

  cfrl_pkg::tok_t   launch_q, launch_d;
  cfrl_pkg::tok_t   tok_w [MAX_ENTRIES+1];
  cfrl_pkg::tok_t   tok_end;

  logic             out_valid_q, out_valid_d;
  logic             out_notify_q, out_notify_d;
  logic             out_acc_q, out_acc_d;
  logic [31:0]      out_drop_q, out_drop_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;

  logic in_acc;

  // A new transaction is taken only when the chain is free and the result
  // register will be empty at this edge.
  assign in_stall_o = (state_q == ST_SEARCH) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Chain of table cells; the launch register feeds the first cell.
  assign tok_w[0] = launch_q;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    cfrl_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX         (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .tok_i   (tok_w[g]),
      .tok_o   (tok_w[g+1])
    );
  end

  assign tok_end = tok_w[MAX_ENTRIES];

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    drop_d         = drop_q;
    allow_all_d    = allow_all_q;
    dflt_d         = dflt_q;
    launch_d       = launch_q;
    launch_d.valid = 1'b0;
    out_valid_d    = out_valid_q && out_stall_i;
    out_notify_d   = out_notify_q;
    out_acc_d      = out_acc_q;
    out_drop_d     = out_drop_q;
    out_cnt_d      = out_cnt_q;

    if (in_acc) begin
      // Token contents for a chain walk; only launched where needed.
      launch_d.is_frame = (mode_i == cfrl_pkg::MODE_FRAME);
      launch_d.ident    = can_id_i;
      launch_d.now      = now_ms_i;
      launch_d.found    = 1'b0;
      launch_d.inserted = 1'b0;
      launch_d.notify   = 1'b0;
      case (mode_i)
        cfrl_pkg::MODE_FRAME: begin
          launch_d.valid    = 1'b1;
          launch_d.ins_en   = allow_all_q;
          launch_d.interval = dflt_q;
          state_d           = ST_SEARCH;
        end
        cfrl_pkg::MODE_ALLOW_ONE: begin
          launch_d.ins_en   = 1'b1;
          launch_d.interval = interval_ms_i;
          if (cmd_length_i == cfrl_pkg::LEN_ALLOW_ONE) begin
            launch_d.valid = 1'b1;
            state_d        = ST_SEARCH;
          end else begin
            out_valid_d  = 1'b1;
            out_notify_d = 1'b0;
            out_acc_d    = 1'b0;
            out_drop_d   = drop_q;
            out_cnt_d    = count_q;
          end
        end
        cfrl_pkg::MODE_DENY_ALL: begin
          out_acc_d = 1'b0;
          if (cmd_length_i == cfrl_pkg::LEN_DENY_ALL) begin
            count_d     = '0;
            drop_d      = 32'd0;
            allow_all_d = 1'b0;
            dflt_d      = 16'd0;
            out_acc_d   = 1'b1;
          end
          out_valid_d  = 1'b1;
          out_notify_d = 1'b0;
          out_drop_d   = drop_d;
          out_cnt_d    = count_d;
        end
        default: begin
          // Allow-all command.
          out_acc_d = 1'b0;
          if (cmd_length_i == cfrl_pkg::LEN_ALLOW_ALL) begin
            count_d     = '0;
            drop_d      = 32'd0;
            allow_all_d = 1'b1;
            dflt_d      = interval_ms_i;
            out_acc_d   = 1'b1;
          end
          out_valid_d  = 1'b1;
          out_notify_d = 1'b0;
          out_drop_d   = drop_d;
          out_cnt_d    = count_d;
        end
      endcase
    end

    // The token leaves the last cell: settle counters and post the result.
    if (tok_end.valid) begin
      state_d = ST_IDLE;
      if (tok_end.inserted) begin
        count_d = count_q + CNT_W'(1);
      end
      if (tok_end.is_frame && tok_end.ins_en && !tok_end.found && !tok_end.inserted) begin
        drop_d = drop_q + 32'd1;
      end
      out_valid_d  = 1'b1;
      out_notify_d = tok_end.is_frame && tok_end.notify;
      out_acc_d    = !tok_end.is_frame && (tok_end.found || tok_end.inserted);
      out_drop_d   = drop_d;
      out_cnt_d    = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drop_q      <= 32'd0;
      allow_all_q <= 1'b0;
      dflt_q      <= 16'd0;
      launch_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      allow_all_q <= allow_all_d;
      dflt_q      <= dflt_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_notify_q <= out_notify_d;
    out_acc_q    <= out_acc_d;
    out_drop_q   <= out_drop_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign notify_o        = out_notify_q;
  assign accepted_o      = out_acc_q;
  assign dropped_count_o = out_drop_q;
  assign entries_used_o  = out_cnt_q;

  // A token only leaves the chain while a walk is under way.
  a_tok_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.valid |-> (state_q == ST_SEARCH))
    else $error("chain token outside a search");

  // The table never holds more identifiers than it has cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  // A finished walk always posts a result in the next cycle.
  a_walk_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.valid |=> out_valid_q)
    else $error("walk ended without a result");

  // A launched token means the controller is busy in the next cycle.
  a_launch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_d.valid |=> (state_q == ST_SEARCH))
    else $error("token launched while idle");

endmodule

[test/can_id_filter_rate_limiter_tb.sv]
`timescale 1ns / 100ps
// Testbench for can_id_filter_rate_limiter: directed and random transactions,
// checked against a scoreboard class. Depends on cfrl_pkg and the block itself.

// Scoreboard: keeps its own copy of the identifier slots, predicts the result
// of every accepted input and checks results against the oldest prediction.
class filter_scoreboard;
  localparam int DEPTH  = cfrl_pkg::MAX_ENTRIES_DEF;
  localparam int USED_W = $clog2(DEPTH + 1);

  typedef struct {
    logic              notify;
    logic              accepted;
    logic [31:0]       dropped;
    logic [USED_W-1:0] used;
  } verdict_t;

  bit [31:0]   slot_ident    [DEPTH];
  bit [15:0]   slot_interval [DEPTH];
  bit [31:0]   slot_last     [DEPTH];
  bit          slot_seen     [DEPTH];
  int unsigned slot_count;
  bit          admit_unknown;
  bit [15:0]   default_gap;
  bit [31:0]   drop_total;

  verdict_t    pending_verdicts [$];
  int unsigned mismatches;

  function int find_slot(bit [31:0] ident);
    for (int i = 0; i < slot_count; i++) begin
      if (slot_ident[i] == ident) return i;
    end
    return -1;
  endfunction

  function int add_slot(bit [31:0] ident, bit [15:0] gap);
    if (slot_count >= DEPTH) return -1;
    slot_ident[slot_count]    = ident;
    slot_interval[slot_count] = gap;
    slot_last[slot_count]     = '0;
    slot_seen[slot_count]     = 1'b0;
    slot_count++;
    return slot_count - 1;
  endfunction

  function void predict_item(logic [1:0] mode, logic [31:0] ident, logic [31:0] now,
                             logic [15:0] gap, logic [7:0] len);
    verdict_t  v;
    int        idx;
    bit [31:0] age;
    v.notify   = 1'b0;
    v.accepted = 1'b0;
    case (mode)
      cfrl_pkg::MODE_FRAME: begin
        idx = find_slot(ident);
        if (idx < 0 && admit_unknown) begin
          idx = add_slot(ident, default_gap);
          if (idx < 0) drop_total++;
        end
        if (idx >= 0) begin
          age = now - slot_last[idx];
          if (!(slot_seen[idx] && slot_interval[idx] != 0 && age < slot_interval[idx])) begin
            slot_seen[idx] = 1'b1;
            slot_last[idx] = now;
            v.notify       = 1'b1;
          end
        end
      end
      cfrl_pkg::MODE_DENY_ALL: begin
        if (len == cfrl_pkg::LEN_DENY_ALL) begin
          slot_count    = 0;
          drop_total    = '0;
          admit_unknown = 1'b0;
          default_gap   = '0;
          v.accepted    = 1'b1;
        end
      end
      cfrl_pkg::MODE_ALLOW_ALL: begin
        if (len == cfrl_pkg::LEN_ALLOW_ALL) begin
          slot_count    = 0;
          drop_total    = '0;
          admit_unknown = 1'b1;
          default_gap   = gap;
          v.accepted    = 1'b1;
        end
      end
      default: begin
        if (len == cfrl_pkg::LEN_ALLOW_ONE) begin
          idx = find_slot(ident);
          if (idx >= 0) begin
            slot_interval[idx] = gap;
            v.accepted         = 1'b1;
          end else if (add_slot(ident, gap) >= 0) begin
            v.accepted = 1'b1;
          end
        end
      end
    endcase
    v.dropped = drop_total;
    v.used    = slot_count[USED_W-1:0];
    pending_verdicts.push_back(v);
  endfunction

  function void check_verdict(logic notify, logic accepted, logic [31:0] dropped,
                              logic [USED_W-1:0] used);
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: notify=%0d accepted=%0d dropped=%0d used=%0d",
                 notify, accepted, dropped, used);
      return;
    end
    want = pending_verdicts.pop_front();
    if (want.notify !== notify || want.accepted !== accepted ||
        want.dropped !== dropped || want.used !== used) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected notify=%0d accepted=%0d dropped=%0d used=%0d, %s",
                 want.notify, want.accepted, want.dropped, want.used,
                 $sformatf("got notify=%0d accepted=%0d dropped=%0d used=%0d",
                           notify, accepted, dropped, used));
    end
  endfunction
endclass

module can_id_filter_rate_limiter_tb;

  localparam int          DEPTH       = cfrl_pkg::MAX_ENTRIES_DEF;
  localparam int          USED_W      = $clog2(DEPTH + 1);
  localparam int          TOTAL_ITEMS = 1500;
  localparam int          POOL_SIZE   = 96;
  // A frame walks the whole chain, so the drain after the last result covers
  // one full pass plus some margin.
  localparam int          DRAIN_CYCLES = DEPTH + 20;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [1:0]        mode_i        = cfrl_pkg::MODE_FRAME;
  logic [31:0]       can_id_i      = '0;
  logic [31:0]       now_ms_i      = '0;
  logic [15:0]       interval_ms_i = '0;
  logic [7:0]        cmd_length_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic              notify_o;
  logic              accepted_o;
  logic [31:0]       dropped_count_o;
  logic [USED_W-1:0] entries_used_o;

  filter_scoreboard sb;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int          sender_idle_pct  = 0;
  int          result_stall_pct = 0;
  int unsigned items_sent       = 0;
  int unsigned cycle_count      = 0;

  // Identifiers shared by the random scenarios, so that frames hit entries
  // that commands have installed. The clock value mostly moves forward in
  // small steps, so rate limiting both holds and releases frames.
  logic [31:0] id_pool [POOL_SIZE];
  logic [31:0] clock_ms = '0;

  can_id_filter_rate_limiter #(
    .MAX_ENTRIES(DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .can_id_i       (can_id_i),
    .now_ms_i       (now_ms_i),
    .interval_ms_i  (interval_ms_i),
    .cmd_length_i   (cmd_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .notify_o       (notify_o),
    .accepted_o     (accepted_o),
    .dropped_count_o(dropped_count_o),
    .entries_used_o (entries_used_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver decides at each falling edge whether to stall the next edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < result_stall_pct);
  end

  // Both channels are observed at the rising edge. The input transaction is
  // predicted before the result is checked, so a result can never overtake
  // the prediction it belongs to.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.predict_item(mode_i, can_id_i, now_ms_i, interval_ms_i, cmd_length_i);
      if (out_valid_o && !out_stall_i)
        sb.check_verdict(notify_o, accepted_o, dropped_count_o, entries_used_o);
    end
  end

  // Presents one input transaction, after a random number of idle cycles, and
  // holds it until the block takes it. Inputs only change at falling edges.
  task automatic send_item(input logic [1:0] mode, input logic [31:0] ident,
                           input logic [31:0] now, input logic [15:0] gap,
                           input logic [7:0] len);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    mode_i        = mode;
    can_id_i      = ident;
    now_ms_i      = now;
    interval_ms_i = gap;
    cmd_length_i  = len;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Intervals: mostly short ones that interact with the clock steps, plus the
  // extremes and fully random values.
  function automatic logic [15:0] pick_gap();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic step_clock();
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 30);
  endtask

  initial begin
    int pick;
    int count;
    logic [7:0] len_pick;
    sb = new;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with no idling on either side.
    // An unknown identifier in deny mode is dropped silently.
    send_item(cfrl_pkg::MODE_FRAME, 32'h0000_0123, 32'h0, 16'h0, 8'h0);
    // Deny-all with a wrong and then a correct length.
    send_item(cfrl_pkg::MODE_DENY_ALL, 32'h0, 32'h0, 16'h0, 8'h00);
    send_item(cfrl_pkg::MODE_DENY_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
              cfrl_pkg::LEN_DENY_ALL);
    // Allow-one: wrong length, then the extreme identifiers and intervals.
    send_item(cfrl_pkg::MODE_ALLOW_ONE, 32'h0, 32'h0, 16'h0, 8'd6);
    send_item(cfrl_pkg::MODE_ALLOW_ONE, 32'h0, 32'h0, 16'h0, cfrl_pkg::LEN_ALLOW_ONE);
    send_item(cfrl_pkg::MODE_ALLOW_ONE, 32'hFFFF_FFFF, 32'h0, 16'hFFFF,
              cfrl_pkg::LEN_ALLOW_ONE);
    // A zero interval never holds a frame back.
    send_item(cfrl_pkg::MODE_FRAME, 32'h0, 32'h0, 16'h0, 8'hFF);
    send_item(cfrl_pkg::MODE_FRAME, 32'h0, 32'h0, 16'hFFFF, 8'h0);
    // First frame passes, then the time difference wraps around zero.
    send_item(cfrl_pkg::MODE_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 16'h0, 8'h0);
    send_item(cfrl_pkg::MODE_FRAME, 32'hFFFF_FFFF, 32'h0000_0005, 16'h0, 8'h0);
    send_item(cfrl_pkg::MODE_FRAME, 32'hFFFF_FFFF, 32'h0000_FFEF, 16'h0, 8'h0);
    // Allow-one on a known identifier only updates its interval.
    send_item(cfrl_pkg::MODE_ALLOW_ONE, 32'h0, 32'h0, 16'd100, cfrl_pkg::LEN_ALLOW_ONE);
    send_item(cfrl_pkg::MODE_FRAME, 32'h0, 32'd50, 16'h0, 8'h0);
    send_item(cfrl_pkg::MODE_FRAME, 32'h0, 32'd100, 16'h0, 8'h0);
    // Allow-all: wrong length, then correct; unknown frames get added.
    send_item(cfrl_pkg::MODE_ALLOW_ALL, 32'h0, 32'h0, 16'd10, 8'hFF);
    send_item(cfrl_pkg::MODE_ALLOW_ALL, 32'h0, 32'h0, 16'd10, cfrl_pkg::LEN_ALLOW_ALL);
    send_item(cfrl_pkg::MODE_FRAME, 32'h1234_5678, 32'd1000, 16'h0, 8'h0);
    send_item(cfrl_pkg::MODE_FRAME, 32'h1234_5678, 32'd1005, 16'h0, 8'h0);
    send_item(cfrl_pkg::MODE_FRAME, 32'h1234_5678, 32'd1010, 16'h0, 8'h0);
    // A length that is right for another command is still wrong.
    send_item(cfrl_pkg::MODE_DENY_ALL, 32'h0, 32'h0, 16'h0, cfrl_pkg::LEN_ALLOW_ALL);
    send_item(cfrl_pkg::MODE_ALLOW_ONE, 32'h1234_5678, 32'h0, 16'd0, cfrl_pkg::LEN_ALLOW_ONE);

    // Random part, in four idling phases of equal length.
    while (items_sent < TOTAL_ITEMS) begin
      case (items_sent * 4 / TOTAL_ITEMS)
        0:       begin sender_idle_pct = 0;  result_stall_pct = 0;  end
        1:       begin sender_idle_pct = 54; result_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  result_stall_pct = 54; end
        default: begin sender_idle_pct = 6;  result_stall_pct = 6;  end
      endcase
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        // Fill the table in allow-all mode until unknown frames are counted
        // as drops, then try allow-one on a new and on a known identifier.
        send_item(cfrl_pkg::MODE_ALLOW_ALL, $urandom, $urandom, pick_gap(),
                  cfrl_pkg::LEN_ALLOW_ALL);
        for (int k = 0; k < DEPTH + 6; k++) begin
          step_clock();
          send_item(cfrl_pkg::MODE_FRAME, id_pool[k], clock_ms, 16'($urandom),
                    8'($urandom));
        end
        repeat (8) begin
          step_clock();
          send_item(cfrl_pkg::MODE_FRAME, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                    clock_ms, 16'($urandom), 8'($urandom));
        end
        send_item(cfrl_pkg::MODE_ALLOW_ONE, id_pool[POOL_SIZE - 1], $urandom, pick_gap(),
                  cfrl_pkg::LEN_ALLOW_ONE);
        send_item(cfrl_pkg::MODE_ALLOW_ONE, id_pool[$urandom_range(0, 15)], $urandom,
                  pick_gap(), cfrl_pkg::LEN_ALLOW_ONE);
      end else if (pick <= 3) begin
        // Rebuild part of the table by hand, then send frames against it.
        if ($urandom_range(0, 1))
          send_item(cfrl_pkg::MODE_DENY_ALL, $urandom, $urandom, 16'($urandom),
                    cfrl_pkg::LEN_DENY_ALL);
        count = $urandom_range(1, 8);
        repeat (count)
          send_item(cfrl_pkg::MODE_ALLOW_ONE, id_pool[$urandom_range(0, 15)], $urandom,
                    pick_gap(), cfrl_pkg::LEN_ALLOW_ONE);
        repeat (15) begin
          step_clock();
          send_item(cfrl_pkg::MODE_FRAME, id_pool[$urandom_range(0, 19)], clock_ms,
                    16'($urandom), 8'($urandom));
        end
      end else if (pick <= 9) begin
        // Frame bursts, mostly on pool identifiers, a few unknown ones.
        repeat (20) begin
          step_clock();
          send_item(cfrl_pkg::MODE_FRAME,
                    ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, 19)],
                    clock_ms, 16'($urandom), 8'($urandom));
        end
      end else begin
        // Noise: any mode, any field, the length mostly wrong.
        repeat (10) begin
          case ($urandom_range(0, 3))
            0:       len_pick = cfrl_pkg::LEN_DENY_ALL;
            1:       len_pick = cfrl_pkg::LEN_ALLOW_ALL;
            2:       len_pick = cfrl_pkg::LEN_ALLOW_ONE;
            default: len_pick = 8'($urandom);
          endcase
          send_item(2'($urandom),
                    ($urandom_range(0, 1)) ? $urandom : id_pool[$urandom_range(0, 19)],
                    $urandom, 16'($urandom), len_pick);
        end
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
design/cfrl_pkg.sv
design/cfrl_cell.sv
design/can_id_filter_rate_limiter.sv
test/can_id_filter_rate_limiter_tb.sv
